>>> sv/assert_macros.svh
// Assertion macros for the file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/kdar_pkg.sv
package kdar_pkg;

    localparam int TIME_W = 16;
    localparam int STEP_W = 8;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // Register indexes of the configuration port.
    localparam logic [CFG_ADDR_W-1:0] CFG_HOLD_DELAY      = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_REPEAT_INTERVAL = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TIME_STEP       = 2'd2;

    // Register values after reset.
    localparam logic [TIME_W-1:0] RST_HOLD_DELAY      = 16'd1000;
    localparam logic [TIME_W-1:0] RST_REPEAT_INTERVAL = 16'd200;
    localparam logic [STEP_W-1:0] RST_TIME_STEP       = 8'd4;

    typedef struct packed {
        logic [TIME_W-1:0] hold_delay;
        logic [TIME_W-1:0] repeat_interval;
        logic [STEP_W-1:0] time_step;
    } t_cfg;

    // What one key lane reports for the current tick.
    typedef struct packed {
        logic fire;
        logic stable;
    } t_lane_res;

endpackage

>>> sv/kdar_lane.sv
module kdar_lane import kdar_pkg::*; #(
    parameter int FILTER_LEN = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_advance,
    input  logic      i_level,
    output t_lane_res o_res
);

    logic [FILTER_LEN-1:0] r_hist;
    logic [FILTER_LEN-1:0] n_hist;
    logic                  r_stable;
    logic                  n_stable;
    logic                  r_prev;
    logic [TIME_W-1:0]     r_hold;
    logic [TIME_W-1:0]     n_hold;
    logic [TIME_W-1:0]     r_thresh;
    logic [TIME_W-1:0]     n_thresh;
    logic [TIME_W:0]       hold_sum;
    logic [TIME_W:0]       thresh_sum;
    logic                  press;
    logic                  repeat_hit;

    assign n_hist     = {r_hist[FILTER_LEN-2:0], i_level};
    assign hold_sum   = {1'b0, r_hold} + (TIME_W + 1)'(i_cfg.time_step);
    assign thresh_sum = {1'b0, r_thresh} + {1'b0, i_cfg.repeat_interval};

    always_comb begin
        n_stable = r_stable;
        n_hold   = r_hold;
        if (&n_hist) begin
            n_stable = 1'b1;
            n_hold   = '0;
        end else if (~|n_hist) begin
            n_stable = 1'b0;
            n_hold   = hold_sum[TIME_W] ? TIME_MAX : hold_sum[TIME_W-1:0];
        end
    end

    // A press is the debounced level falling from released to pressed.
    assign press      = r_prev & ~n_stable;
    assign repeat_hit = (n_hold != '0) && (n_hold > r_thresh);

    always_comb begin
        n_thresh = r_thresh;
        if (n_hold == '0) begin
            n_thresh = i_cfg.hold_delay;
        end else if (repeat_hit) begin
            n_thresh = thresh_sum[TIME_W] ? TIME_MAX : thresh_sum[TIME_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist   <= '1;
            r_stable <= 1'b1;
            r_prev   <= 1'b1;
            r_hold   <= '0;
            r_thresh <= RST_HOLD_DELAY;
        end else if (i_advance) begin
            r_hist   <= n_hist;
            r_stable <= n_stable;
            r_prev   <= n_stable;
            r_hold   <= n_hold;
            r_thresh <= n_thresh;
        end
    end

    assign o_res.fire   = press | repeat_hit;
    assign o_res.stable = n_stable;

endmodule

>>> sv/kdar_merge.sv
module kdar_merge import kdar_pkg::*; #(
    parameter int NUM_KEYS = 4,
    parameter int OUT_W    = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_lane_res        i_lane [NUM_KEYS],
    input  logic             i_load,
    input  logic             i_m_tready,
    output logic             o_ready,
    output logic             o_m_tvalid,
    output logic [OUT_W-1:0] o_m_tdata
);

    logic                r_valid;
    logic [NUM_KEYS-1:0] r_event;
    logic [NUM_KEYS-1:0] r_stable;
    logic [NUM_KEYS-1:0] n_event;
    logic [NUM_KEYS-1:0] n_stable;

    // The result register frees up in the same cycle as its transfer.
    assign o_ready = ~r_valid | i_m_tready;

    always_comb begin
        for (int k = 0; k < NUM_KEYS; k++) begin
            n_event[k]  = i_lane[k].fire;
            n_stable[k] = i_lane[k].stable;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_event  <= n_event;
            r_stable <= n_stable;
        end
    end

    always_comb begin
        o_m_tdata                        = '0;
        o_m_tdata[NUM_KEYS-1:0]          = r_event;
        o_m_tdata[2*NUM_KEYS-1:NUM_KEYS] = r_stable;
    end

    assign o_m_tvalid = r_valid;

endmodule

>>> sv/key_debounce_with_auto_repeat_unit.sv
// Channel        Dir  Signals                      Contents of a transfer
// -------------  ---  ---------------------------  ----------------------------------
// scan tick      in   i_s_tvalid/o_s_tready/data   key_levels
// key result     out  o_m_tvalid/i_m_tready/data   event_mask, stable_levels
// configuration  in   i_cfg_we/addr/wdata          one register write per cycle
//
// One scan tick is taken every cycle unless the input is stalled; its result appears in
// the cycle after the transfer, set by the single result register behind the key lanes.
// Reset is synchronous and active low; it returns every key to released and
// the registers to their default values.
// A stalled result holds the input only while the result register is full and
// the result side is not ready.
`include "assert_macros.svh"

module key_debounce_with_auto_repeat_unit import kdar_pkg::*; #(
    parameter int NUM_KEYS   = 4,
    parameter int FILTER_LEN = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // key_levels [NUM_KEYS-1:0], zero padding above
    input  logic [((NUM_KEYS + 7) / 8) * 8 - 1:0] i_s_tdata,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // event_mask [NUM_KEYS-1:0], stable_levels [2*NUM_KEYS-1:NUM_KEYS], zero padding above
    output logic [((2 * NUM_KEYS + 7) / 8) * 8 - 1:0] o_m_tdata,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    input  logic                                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]                 i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]                 i_cfg_wdata
);

    localparam int OUT_W = ((2 * NUM_KEYS + 7) / 8) * 8;

    t_cfg      r_cfg;
    t_lane_res lane_res [NUM_KEYS];
    logic      in_xfer;

    // Register writes: an index outside the list is simply dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_delay      <= RST_HOLD_DELAY;
            r_cfg.repeat_interval <= RST_REPEAT_INTERVAL;
            r_cfg.time_step       <= RST_TIME_STEP;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_HOLD_DELAY: begin
                    r_cfg.hold_delay <= i_cfg_wdata;
                end
                CFG_REPEAT_INTERVAL: begin
                    r_cfg.repeat_interval <= i_cfg_wdata;
                end
                CFG_TIME_STEP: begin
                    r_cfg.time_step <= i_cfg_wdata[STEP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // A tick moves every key lane forward at once; the lanes never stall on
    // their own, so the only back-pressure is from the result register.
    assign in_xfer = i_s_tvalid & o_s_tready;

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
        kdar_lane #(
            .FILTER_LEN (FILTER_LEN)
        ) u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cfg     (r_cfg),
            .i_advance (in_xfer),
            .i_level   (i_s_tdata[k]),
            .o_res     (lane_res[k])
        );
    end

    // The merge stage gathers the lane flags into one result word and holds
    // it until the downstream side takes the transfer.
    kdar_merge #(
        .NUM_KEYS (NUM_KEYS),
        .OUT_W    (OUT_W)
    ) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_lane     (lane_res),
        .i_load     (in_xfer),
        .i_m_tready (i_m_tready),
        .o_ready    (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata)
    );

    // A released key has no down time, so it can never report an event.
    `ASSERT_SAME(a_event_only_pressed, i_clk, i_rst_n, o_m_tvalid,
        ((o_m_tdata[NUM_KEYS-1:0] & o_m_tdata[2*NUM_KEYS-1:NUM_KEYS]) == '0),
        "event reported for a released key")
    // Every accepted tick leaves a result waiting in the next cycle.
    `ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, in_xfer, o_m_tvalid,
        "accepted tick produced no result")
    // A full result register that is not being drained must block the input.
    `ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n, (o_m_tvalid && !i_m_tready),
        !o_s_tready, "input accepted over a pending result")

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

// Testbench for the four-key debouncer with auto-repeat.
//
// Scan ticks are queued by the main initial block and handed to the block by
// a clocked driver. Each tick is predicted at the moment its transfer
// completes. A clocked monitor takes every result transfer and compares it
// against the oldest prediction still waiting. Both sides idle at random, and
// there are calm stretches in which they do not idle at all. Once during the
// run the result side holds off for a long stretch, so that the single result
// register fills and the block has to stall its input.
module tb;
    import kdar_pkg::*;

    localparam int NUM_KEYS = 4;

    // The block decodes only three register indexes; the fourth must be ignored.
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 2'd3;

    // Result transfer, event_mask in the low nibble and stable_levels above it.
    typedef struct packed {
        logic [NUM_KEYS-1:0] stable_levels;
        logic [NUM_KEYS-1:0] event_mask;
    } t_key_res;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic [7:0]            i_s_tdata   = '0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [7:0]            o_m_tdata;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    // Scan ticks waiting to be offered, and the key results predicted for
    // ticks that have already been transferred.
    logic [NUM_KEYS-1:0] tick_queue [$];
    t_key_res            pending_results [$];

    // Shadow of the block's registers and of its per-key state.
    logic [TIME_W-1:0]   shadow_hold  = RST_HOLD_DELAY;
    logic [TIME_W-1:0]   shadow_ival  = RST_REPEAT_INTERVAL;
    logic [STEP_W-1:0]   shadow_step  = RST_TIME_STEP;
    logic [7:0]          sample_hist [NUM_KEYS];
    logic [NUM_KEYS-1:0] debounced    = '1;
    logic [NUM_KEYS-1:0] last_debounced = '1;
    logic [TIME_W-1:0]   down_time   [NUM_KEYS];
    logic [TIME_W-1:0]   repeat_at   [NUM_KEYS];

    // Key press generator: each key alternates between pressed and released
    // runs, with contact bounce after each change and the odd stray glitch.
    logic [NUM_KEYS-1:0] gen_down = '0;
    int                  gen_run    [NUM_KEYS];
    int                  gen_bounce [NUM_KEYS];

    // Driver and monitor state.
    logic [NUM_KEYS-1:0] scan_cur   = '0;
    bit                  scan_live  = 1'b0;
    bit                  scan_calm  = 1'b0;
    int                  scan_gap   = 0;
    bit                  sink_calm  = 1'b0;
    int                  sink_wait  = 0;
    logic                sink_hold  = 1'b0;
    int                  result_count = 0;
    int                  fail_count   = 0;

    key_debounce_with_auto_repeat_unit #(
        .NUM_KEYS   (NUM_KEYS),
        .FILTER_LEN (8)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    endfunction

    // Advances the shadow state by one scan tick and returns the key result
    // that the block must report for it. The filter stage runs first, then the
    // event stage sees the freshly debounced state in the same tick.
    task automatic debounce_tick(input logic [NUM_KEYS-1:0] levels, output t_key_res res);
        logic fire;
        res = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            sample_hist[k] = {sample_hist[k][6:0], levels[k]};
            if (sample_hist[k] == 8'hFF) begin
                debounced[k] = 1'b1;
                down_time[k] = '0;
            end else if (sample_hist[k] == 8'h00) begin
                debounced[k] = 1'b0;
                down_time[k] = sat_add(down_time[k], TIME_W'(shadow_step));
            end

            fire = 1'b0;
            // Only a released-to-pressed change counts as a press.
            if (last_debounced[k] != debounced[k]) begin
                if (last_debounced[k])
                    fire = 1'b1;
                last_debounced[k] = debounced[k];
            end
            // Repeats while held; a press and a repeat in one tick share the bit.
            if (down_time[k] != '0) begin
                if (down_time[k] > repeat_at[k]) begin
                    fire = 1'b1;
                    repeat_at[k] = sat_add(repeat_at[k], shadow_ival);
                end
            end else begin
                repeat_at[k] = shadow_hold;
            end

            res.event_mask[k]    = fire;
            res.stable_levels[k] = debounced[k];
        end
    endtask

    task automatic next_levels(output logic [NUM_KEYS-1:0] levels);
        int pick;
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (gen_run[k] == 0) begin
                gen_down[k] = ~gen_down[k];
                pick = $urandom_range(0, 11);
                if (pick == 0)
                    gen_run[k] = $urandom_range(1, 7);      // too short to settle
                else if (pick < 3)
                    gen_run[k] = $urandom_range(100, 500);  // long hold for repeats
                else
                    gen_run[k] = $urandom_range(9, 60);
                gen_bounce[k] = $urandom_range(0, 6);
            end
            gen_run[k]--;
            levels[k] = ~gen_down[k];
            if (gen_bounce[k] > 0) begin
                gen_bounce[k]--;
                if ($urandom_range(0, 2) == 0)
                    levels[k] = ~levels[k];
            end else if ($urandom_range(0, 63) == 0) begin
                levels[k] = ~levels[k];
            end
        end
    endtask

    task automatic note_fail(input string what);
        if (fail_count < 10)
            $display("%0t: %s", $realtime, what);
        fail_count++;
    endtask

    // The shadow copy is updated straight away: writes are only made while
    // no tick is in flight.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_HOLD_DELAY:      shadow_hold = val;
            CFG_REPEAT_INTERVAL: shadow_ival = val;
            CFG_TIME_STEP:       shadow_step = val[STEP_W-1:0];
            default: ;
        endcase
    endtask

    // The block is idle once every queued tick has been transferred and its
    // result has come back; an extra wait then covers the result register.
    task automatic wait_idle();
        while (tick_queue.size() != 0 || scan_live || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [TIME_W-1:0] hold, input logic [TIME_W-1:0] ival,
                             input logic [STEP_W-1:0] step, input int count);
        logic [NUM_KEYS-1:0] levels;
        wait_idle();
        write_reg(CFG_HOLD_DELAY, hold);
        write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
        write_reg(CFG_REPEAT_INTERVAL, ival);
        write_reg(CFG_TIME_STEP, CFG_DATA_W'(step));
        for (int n = 0; n < count; n++) begin
            next_levels(levels);
            tick_queue.push_back(levels);
        end
    endtask

    // Driver: offers queued ticks, predicts each one as its transfer completes,
    // then waits a random number of cycles before offering the next.
    always @(posedge i_clk) begin
        t_key_res res;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= '0;
            scan_live  = 1'b0;
            scan_gap   = 0;
        end else begin
            if (scan_live && o_s_tready) begin
                debounce_tick(scan_cur, res);
                pending_results.push_back(res);
                scan_live = 1'b0;
                if ($urandom_range(0, 39) == 0)
                    scan_calm = ~scan_calm;
                scan_gap = scan_calm ? 0 : $urandom_range(0, 16);
            end
            if (!scan_live) begin
                if (scan_gap > 0) begin
                    scan_gap--;
                end else if (tick_queue.size() != 0) begin
                    scan_cur  = tick_queue.pop_front();
                    scan_live = 1'b1;
                end
            end
            i_s_tvalid <= scan_live;
            if (scan_live)
                i_s_tdata <= {4'b0000, scan_cur};
        end
    end

    // Monitor: checks every result transfer against the oldest prediction and
    // then stalls the result side for a random number of cycles.
    always @(posedge i_clk) begin
        t_key_res got;
        t_key_res want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            sink_wait  = 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got = o_m_tdata;
                result_count++;
                if (pending_results.size() == 0) begin
                    note_fail($sformatf("unexpected result %h", got));
                end else begin
                    want = pending_results.pop_front();
                    if (got.event_mask !== want.event_mask)
                        note_fail($sformatf("event_mask expected %h got %h",
                                            want.event_mask, got.event_mask));
                    if (got.stable_levels !== want.stable_levels)
                        note_fail($sformatf("stable_levels expected %h got %h",
                                            want.stable_levels, got.stable_levels));
                end
                if ($urandom_range(0, 39) == 0)
                    sink_calm = ~sink_calm;
                sink_wait = sink_calm ? 0 : $urandom_range(0, 16);
            end
            if (sink_wait > 0) begin
                i_m_tready <= 1'b0;
                sink_wait--;
            end else begin
                i_m_tready <= !sink_hold;
            end
        end
    end

    // Long hold-off on the result side partway through the run, while the
    // driver keeps offering ticks.
    initial begin
        wait (result_count >= 400);
        @(posedge i_clk);
        sink_hold <= 1'b1;
        repeat (200) @(posedge i_clk);
        sink_hold <= 1'b0;
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        for (int k = 0; k < NUM_KEYS; k++) begin
            sample_hist[k] = 8'hFF;
            down_time[k]   = '0;
            repeat_at[k]   = RST_HOLD_DELAY;
            gen_run[k]     = $urandom_range(0, 20);
            gen_bounce[k]  = 0;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed ticks at the reset settings: all keys pressed until the
        // filter settles, then released, then a bouncing pattern that must
        // leave the debounced state alone.
        repeat (8) tick_queue.push_back(4'h0);
        repeat (8) tick_queue.push_back(4'hF);
        tick_queue.push_back(4'hA);
        tick_queue.push_back(4'h5);
        tick_queue.push_back(4'hA);
        tick_queue.push_back(4'h5);

        // Zero hold delay with zero interval: the first settled tick gives a
        // press and a repeat together, and then a repeat fires every tick.
        wait_idle();
        write_reg(CFG_HOLD_DELAY, '0);
        write_reg(CFG_REPEAT_INTERVAL, '0);
        write_reg(CFG_TIME_STEP, CFG_DATA_W'(1));
        repeat (9) tick_queue.push_back(4'hE);
        repeat (2) tick_queue.push_back(4'hF);

        run_phase(16'd0,     16'd0,     8'd1,   120);
        // Down time saturates but can never exceed the saturated threshold.
        run_phase(16'd65535, 16'd1,     8'd255, 300);
        // The threshold jumps to its ceiling after the first repeat.
        run_phase(16'd0,     16'd65535, 8'd255, 100);
        run_phase(16'd40,    16'd10,    8'd4,   250);
        run_phase(RST_HOLD_DELAY, RST_REPEAT_INTERVAL, RST_TIME_STEP, 300);
        // With no time step the down time stays at zero and nothing repeats.
        run_phase(16'd100,   16'd1,     8'd0,   80);
        run_phase(16'd65535, 16'd65535, 8'd1,   60);
        for (int p = 0; p < 6; p++)
            run_phase(TIME_W'($urandom_range(0, 300)), TIME_W'($urandom_range(1, 100)),
                      STEP_W'($urandom_range(1, 255)), 55);

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (pending_results.size() != 0)
            note_fail($sformatf("%0d results never arrived", pending_results.size()));
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> key_debounce_with_auto_repeat_unit.f
+incdir+sv
sv/kdar_pkg.sv
sv/kdar_lane.sv
sv/kdar_merge.sv
sv/key_debounce_with_auto_repeat_unit.sv
sim/tb.sv
